### rtl/opstk_pkg.sv
package opstk_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int CELL_WIDTH  = 64;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [DATA_W-1:0]     data_t;
  typedef logic [CELL_WIDTH-1:0] cell_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_DUP  = 2'd1,
    REQ_SWAP = 2'd2,
    REQ_POP  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BAD_REF  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic wr_first;
    logic wr_second;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic long_op;
    logic swap_pend;
  } dp_stat_t;

endpackage

### rtl/opstk_ram.sv
module opstk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

### rtl/opstk_ctrl.sv
module opstk_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  opstk_pkg::dp_stat_t  stat,
  output opstk_pkg::ctrl_cmd_t cmd,
  output logic                 busy
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_FINISH = 3'b010,
    S_SWAP2  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.accept    = 1'b0;
    cmd.wr_first  = 1'b0;
    cmd.wr_second = 1'b0;
    cmd.finish    = 1'b0;
    busy          = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          if (stat.long_op) begin
            state_next = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        cmd.wr_first = 1'b1;
        if (stat.swap_pend) begin
          state_next = S_SWAP2;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SWAP2: begin
        cmd.wr_second = 1'b1;
        cmd.finish    = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/opstk_dp.sv
module opstk_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  opstk_pkg::ctrl_cmd_t cmd,
  output opstk_pkg::dp_stat_t  stat,
  input  logic [1:0]           req_type,
  input  opstk_pkg::data_t     operand,
  output logic                 done,
  output opstk_pkg::data_t     popped_value,
  output opstk_pkg::cnt_t      depth_after,
  output logic [1:0]           status
);

  opstk_pkg::cnt_t    depth, depth_next;
  opstk_pkg::req_t    req, op_reg;
  opstk_pkg::status_t st;
  logic               full, in_range, ok;
  opstk_pkg::addr_t   top_addr, src_addr;
  opstk_pkg::addr_t   dst_addr, oth_addr;

  logic               wr_en, rd_en;
  opstk_pkg::addr_t   wr_addr, rd_addr_a, rd_addr_b;
  opstk_pkg::cell_t   wr_data, rd_data_a, rd_data_b;

  assign req      = opstk_pkg::req_t'(req_type);
  assign full     = (depth == opstk_pkg::cnt_t'(opstk_pkg::STACK_DEPTH));
  // The whole operand takes part in the range check, so large values fail too.
  assign in_range = (operand[opstk_pkg::DATA_W-1:opstk_pkg::CNT_W] == '0) &&
                    (operand[opstk_pkg::CNT_W-1:0] < depth);
  assign top_addr = opstk_pkg::addr_t'(depth - opstk_pkg::cnt_t'(1));
  assign src_addr = opstk_pkg::addr_t'(depth - opstk_pkg::cnt_t'(1) -
                    opstk_pkg::cnt_t'(operand[opstk_pkg::ADDR_W-1:0]));

  always_comb begin
    st         = opstk_pkg::ST_OK;
    depth_next = depth;
    case (req)
      opstk_pkg::REQ_PUSH: begin
        if (full) begin
          st = opstk_pkg::ST_OVERFLOW;
        end else begin
          depth_next = depth + opstk_pkg::cnt_t'(1);
        end
      end
      opstk_pkg::REQ_DUP: begin
        if (full) begin
          st = opstk_pkg::ST_OVERFLOW;
        end else if (!in_range) begin
          st = opstk_pkg::ST_BAD_REF;
        end else begin
          depth_next = depth + opstk_pkg::cnt_t'(1);
        end
      end
      opstk_pkg::REQ_SWAP: begin
        if (!in_range) begin
          st = opstk_pkg::ST_BAD_REF;
        end
      end
      opstk_pkg::REQ_POP: begin
        if (depth == '0) begin
          st = opstk_pkg::ST_EMPTY;
        end else begin
          depth_next = depth - opstk_pkg::cnt_t'(1);
        end
      end
      default: begin
        st = opstk_pkg::ST_OK;
      end
    endcase
  end

  assign ok           = (st == opstk_pkg::ST_OK);
  assign stat.long_op = ok && (req != opstk_pkg::REQ_PUSH);
  assign stat.swap_pend = (op_reg == opstk_pkg::REQ_SWAP);

  // A push writes at acceptance; dup writes its copy and swap writes the top
  // in the first finishing cycle; swap writes the other cell last.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = dst_addr;
    wr_data   = rd_data_a;
    rd_en     = 1'b0;
    rd_addr_a = top_addr;
    rd_addr_b = src_addr;
    if (cmd.accept) begin
      if (ok && req == opstk_pkg::REQ_PUSH) begin
        wr_en   = 1'b1;
        wr_addr = opstk_pkg::addr_t'(depth);
        wr_data = operand[opstk_pkg::CELL_WIDTH-1:0];
      end
      rd_en = stat.long_op;
      if (req == opstk_pkg::REQ_DUP) begin
        rd_addr_a = src_addr;
      end
    end else if (cmd.wr_first) begin
      if (op_reg == opstk_pkg::REQ_DUP) begin
        wr_en = 1'b1;
      end else if (op_reg == opstk_pkg::REQ_SWAP) begin
        wr_en   = 1'b1;
        wr_data = rd_data_b;
      end
    end else if (cmd.wr_second) begin
      wr_en   = 1'b1;
      wr_addr = oth_addr;
    end
  end

  opstk_ram #(
    .WIDTH(opstk_pkg::CELL_WIDTH),
    .DEPTH(opstk_pkg::STACK_DEPTH)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth  <= '0;
      done   <= 1'b0;
      op_reg <= opstk_pkg::REQ_PUSH;
    end else begin
      done <= (cmd.accept && !stat.long_op) || cmd.finish;
      if (cmd.accept) begin
        depth  <= depth_next;
        op_reg <= req;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dst_addr     <= (req == opstk_pkg::REQ_DUP) ? opstk_pkg::addr_t'(depth) : top_addr;
      oth_addr     <= src_addr;
      depth_after  <= depth_next;
      status       <= st;
      popped_value <= '0;
    end else if (cmd.finish && op_reg == opstk_pkg::REQ_POP) begin
      popped_value <= opstk_pkg::data_t'(rd_data_a);
    end
  end

endmodule

### rtl/operand_stack_with_pick_swap.sv
// Channel   Ports                                   Transaction
// request   start, busy, req_type, operand          start high while busy low
// result    done, popped_value, depth_after, status one cycle with done high
//
// Push and every rejected request complete when accepted; the result shows in the next cycle.
// Dup and pop pass through a finishing state and swap through a second one as well, set by the
// registered read of the cell memory and its single write port. Each request gives exactly one result.
// Reset clears the element count and the result strobe; cells hold no reset.
// The receiver cannot stall; a new request may be taken while a result shows.
module operand_stack_with_pick_swap (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              req_type,
  input  logic [63:0]             operand,
  output logic                    done,
  output logic [63:0]             popped_value,
  output logic [opstk_pkg::CNT_W-1:0] depth_after,
  output logic [1:0]              status
);

  opstk_pkg::ctrl_cmd_t cmd;
  opstk_pkg::dp_stat_t  stat;

  opstk_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  opstk_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_type    (req_type),
    .operand     (operand),
    .done        (done),
    .popped_value(popped_value),
    .depth_after (depth_after),
    .status      (status)
  );

endmodule

### verif/opstk_checker.sv
module opstk_checker
  import opstk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        req_type,
  input  logic [63:0]       operand,
  input  logic              done,
  input  logic [63:0]       popped_value,
  input  logic [CNT_W-1:0]  depth_after,
  input  logic [1:0]        status,
  output int                mismatches,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    data_t   popped;
    cnt_t    depth;
    status_t st;
  } stack_result_t;

  cell_t         cells [STACK_DEPTH];
  cnt_t          depth = '0;
  stack_result_t expected_results [$];
  int            errors = 0;

  // Applies one request to the shadow stack and queues the result it must give.
  task automatic apply_request(input req_t kind, input data_t arg);
    stack_result_t res;
    addr_t         top_idx;
    addr_t         other_idx;
    cell_t         tmp;
    res.popped = '0;
    res.st = ST_OK;
    case (kind)
      REQ_PUSH: begin
        if (depth >= STACK_DEPTH) begin
          res.st = ST_OVERFLOW;
        end else begin
          cells[depth] = arg[CELL_WIDTH-1:0];
          depth = depth + 1'b1;
        end
      end
      REQ_DUP: begin
        if (depth >= STACK_DEPTH) begin
          res.st = ST_OVERFLOW;
        end else if (arg >= depth) begin
          res.st = ST_BAD_REF;
        end else begin
          cells[depth] = cells[depth - 1 - arg[CNT_W-1:0]];
          depth = depth + 1'b1;
        end
      end
      REQ_SWAP: begin
        if (arg >= depth) begin
          res.st = ST_BAD_REF;
        end else begin
          top_idx = depth - 1;
          other_idx = top_idx - arg[ADDR_W-1:0];
          tmp = cells[top_idx];
          cells[top_idx] = cells[other_idx];
          cells[other_idx] = tmp;
        end
      end
      default: begin
        if (depth == 0) begin
          res.st = ST_EMPTY;
        end else begin
          depth = depth - 1'b1;
          res.popped = data_t'(cells[depth]);
        end
      end
    endcase
    res.depth = depth;
    expected_results.push_back(res);
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    if (rst) begin
      depth = '0;
      expected_results.delete();
    end else begin
      // The result of a transaction shows in the cycle after it at the earliest,
      // so results are checked before this edge's request is predicted.
      if (done !== 1'b0) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected: popped %h depth %0d status %0d",
                   $time, popped_value, depth_after, status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (popped_value !== want.popped) begin
            $display("%0t: popped_value expected %h actual %h",
                     $time, want.popped, popped_value);
            errors++;
          end
          if (depth_after !== want.depth) begin
            $display("%0t: depth_after expected %0d actual %0d",
                     $time, want.depth, depth_after);
            errors++;
          end
          if (status !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        apply_request(req_t'(req_type), operand);
      end
    end
    mismatches <= errors;
    outstanding <= expected_results.size();
  end

endmodule

### verif/tb_operand_stack_with_pick_swap.sv
module tb_operand_stack_with_pick_swap;
  timeunit 1ns;
  timeprecision 1ps;
  import opstk_pkg::*;

  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_t;

  localparam int RANDOM_ITEMS = 1800;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        req_type;
  logic [63:0]       operand;
  logic              done;
  logic [63:0]       popped_value;
  logic [CNT_W-1:0]  depth_after;
  logic [1:0]        status;
  int                mismatches;
  int                outstanding;

  int shadow_depth;
  int kind_count [4];
  int full_hits;
  int empty_hits;
  bit no_idle;

  operand_stack_with_pick_swap dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .operand      (operand),
    .done         (done),
    .popped_value (popped_value),
    .depth_after  (depth_after),
    .status       (status)
  );

  opstk_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .operand      (operand),
    .done         (done),
    .popped_value (popped_value),
    .depth_after  (depth_after),
    .status       (status),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("operand_stack_with_pick_swap regression: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic data_t push_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return data_t'(1) << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly a depth inside the stack, with the top and bottom favored; the rest
  // sits just past the stack or is a huge value with high bits set.
  function automatic data_t depth_ref();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80 && shadow_depth > 0) begin
      if (r < 8) return data_t'(shadow_depth - 1);
      if (r < 16) return '0;
      return data_t'($urandom_range(0, shadow_depth - 1));
    end
    if (r < 90) return data_t'(shadow_depth + $urandom_range(0, 3));
    return {$urandom, $urandom} | (data_t'(1) << $urandom_range(9, 63));
  endfunction

  function automatic req_t pick_kind(input phase_t phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      PH_FILL:  return r < 55 ? REQ_PUSH : r < 80 ? REQ_DUP : r < 90 ? REQ_SWAP : REQ_POP;
      PH_DRAIN: return r < 10 ? REQ_PUSH : r < 15 ? REQ_DUP : r < 25 ? REQ_SWAP : REQ_POP;
      default:  return req_t'(r % 4);
    endcase
  endfunction

  function automatic data_t pick_operand(input req_t kind);
    case (kind)
      REQ_PUSH: return push_value();
      REQ_POP:  return {$urandom, $urandom};
      default:  return depth_ref();
    endcase
  endfunction

  // Presents one request, waits for its transaction and follows the depth so
  // that later depth references can be aimed.
  task automatic issue(input req_t kind, input data_t arg);
    int gap;
    int was;
    req_type <= kind;
    operand <= arg;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    was = shadow_depth;
    case (kind)
      REQ_PUSH: if (shadow_depth < STACK_DEPTH) shadow_depth++;
      REQ_DUP:  if (shadow_depth < STACK_DEPTH && arg < shadow_depth) shadow_depth++;
      REQ_POP:  if (shadow_depth > 0) shadow_depth--;
      default:  ;
    endcase
    if (shadow_depth == STACK_DEPTH && was != STACK_DEPTH) full_hits++;
    if (shadow_depth == 0 && was != 0) empty_hits++;
    kind_count[kind]++;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      req_type <= $urandom;
      operand <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int     total;
    int     round;
    int     left;
    bit     reached;
    phase_t phase;
    req_t   kind;
    rst <= 1'b1;
    start <= 1'b0;
    req_type <= '0;
    operand <= '0;
    shadow_depth = 0;
    full_hits = 0;
    empty_hits = 0;
    no_idle = 1'b0;
    foreach (kind_count[i]) kind_count[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty-stack errors, then the field extremes and boundary references.
    issue(REQ_POP, '1);
    issue(REQ_DUP, '0);
    issue(REQ_SWAP, '0);
    issue(REQ_PUSH, '0);
    issue(REQ_PUSH, '1);
    issue(REQ_SWAP, '0);
    issue(REQ_SWAP, 64'd1);
    issue(REQ_DUP, 64'd1);
    issue(REQ_DUP, 64'd3);
    issue(REQ_DUP, '1);
    issue(REQ_SWAP, 64'h8000_0000_0000_0000);
    issue(REQ_SWAP, 64'h0000_0001_0000_0000);
    issue(REQ_SWAP, 64'd2);
    issue(REQ_PUSH, 64'hA5A5_A5A5_A5A5_A5A5);
    issue(REQ_PUSH, 64'h5A5A_5A5A_5A5A_5A5A);
    issue(REQ_DUP, '0);
    issue(REQ_SWAP, 64'd5);
    issue(REQ_SWAP, 64'd6);
    repeat (6) issue(REQ_POP, '1);
    issue(REQ_POP, '0);

    // Fill, mixed and drain rounds so that both the full and the empty stack
    // are reached repeatedly with random content.
    total = 0;
    round = 0;
    while (total < RANDOM_ITEMS) begin
      phase = phase_t'(round % 3);
      no_idle = ($urandom_range(0, 3) == 0);
      left = (phase == PH_MIXED) ? 150 : 20;
      reached = 1'b0;
      while (total < RANDOM_ITEMS && left > 0) begin
        kind = pick_kind(phase);
        issue(kind, pick_operand(kind));
        total++;
        if (phase == PH_FILL && shadow_depth == STACK_DEPTH) reached = 1'b1;
        if (phase == PH_DRAIN && shadow_depth == 0) reached = 1'b1;
        if (phase == PH_MIXED || reached) left--;
      end
      round++;
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d push, %0d dup, %0d swap and %0d pop transactions.",
             kind_count[REQ_PUSH], kind_count[REQ_DUP], kind_count[REQ_SWAP],
             kind_count[REQ_POP]);
    $display("The stack filled %0d times and emptied %0d times; %0d mismatches.",
             full_hits, empty_hits, mismatches);
    if (mismatches == 0) begin
      $display("operand_stack_with_pick_swap regression: pass");
    end else begin
      $display("operand_stack_with_pick_swap regression: fail");
    end
    $finish;
  end

endmodule
